[rtl/tvtc_pkg.sv]
// shared types and constants for the triangle vertex transform and cull block
package tvtc_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int MAT_FRAC = 12;
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 17;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W = PROD_W + 2;
   localparam int HALF_X = 320;
   localparam int HALF_Y = 240;

   localparam logic [2:0] CSR_ROW0 = 3'd0;
   localparam logic [2:0] CSR_ROW1 = 3'd1;
   localparam logic [2:0] CSR_ROW2 = 3'd2;
   localparam logic [2:0] CSR_ROW3 = 3'd3;
   localparam logic [2:0] CSR_COLOUR = 3'd4;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MUL    = 8'b0000_0010,
      ST_DECIDE = 8'b0000_0100,
      ST_DIVS   = 8'b0000_1000,
      ST_DIVW   = 8'b0001_0000,
      ST_SHADE  = 8'b0010_0000,
      ST_COL    = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } state_type;
endpackage

[rtl/tvtc_mul.sv]
// shared signed multiplier with registered product
module tvtc_mul (
   input  logic                                   clock,
   input  logic signed [tvtc_pkg::MUL_A_W-1:0]    a,
   input  logic signed [tvtc_pkg::MUL_B_W-1:0]    b,
   output logic signed [tvtc_pkg::PROD_W-1:0]     prod
);
   logic signed [tvtc_pkg::PROD_W-1:0] prod_ff;
   logic signed [tvtc_pkg::PROD_W-1:0] prod_in;

   assign prod_in = tvtc_pkg::PROD_W'(a) * tvtc_pkg::PROD_W'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

[rtl/tvtc_div.sv]
// iterative restoring divider, one quotient bit per cycle
module tvtc_div #(
   parameter int NUM_W = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [31:0]      denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in, q_ff, q_in;
   logic [31:0]      rem_ff, rem_in, den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [32:0]      trial;
   logic [32:0]      diff;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign diff = trial - {1'b0, den_ff};

   always_comb begin
      num_in = num_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = numer;
         den_in = denom;
         rem_in = '0;
         q_in = '0;
         cnt_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (!diff[32]) begin
            rem_in = diff[31:0];
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      q_ff <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

[rtl/triangle_vertex_transform_cull_top.sv]
// triangle vertex transform, perspective divide, cull, shading and viewport mapping
// flow: a vertex is taken in idle and run through the matrix; the first two vertices
// are held as open corners, the third closes the triangle, which is depth culled or
// divided nine times, side culled, shaded and sent as 4 words; one vertex at a time:
// no new vertex is taken until the last is done, and output back-pressure stalls the block
// reset: synchronous active high, clears matrix, colour, held corners and control
module triangle_vertex_transform_cull_top #(
   parameter int FRAC_BITS = tvtc_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_vertex_x,
   input  logic signed [31:0] req_vertex_y,
   input  logic signed [31:0] req_vertex_z,
   input  logic signed [31:0] req_vertex_w,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_screen_x,
   output logic signed [31:0] rsp_screen_y,
   output logic [31:0]        rsp_point_depth,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic               rsp_last_point,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);
   localparam int NUM_W = 32 + FRAC_BITS;
   localparam longint ONE_Q = longint'(1) << FRAC_BITS;
   localparam longint SHADE_MIN = (ONE_Q * 5 + 50) / 100;
   localparam int DEPTH_SHIFT = 31 - FRAC_BITS;

   tvtc_pkg::state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [1:0]  corner_ff, corner_in;
   logic [1:0]  vtx_ff, vtx_in, comp_ff, comp_in;
   logic [63:0] row_ff [4];
   logic [23:0] colour_ff;
   logic signed [31:0] vin_ff [4];
   logic signed [31:0] t_ff [4];
   logic signed [31:0] held_x_ff [2], held_y_ff [2], held_z_ff [2], held_w_ff [2];
   logic signed [31:0] dx_ff [3], dy_ff [3], dz_ff [3];
   logic signed [tvtc_pkg::ACC_W-1:0] acc_ff;
   logic [FRAC_BITS:0] shade_ff;
   logic [7:0]  col_ff [3];
   logic        neg_ff, dzero_ff, npos_ff;

   logic signed [31:0] ox_ff, oy_ff;
   logic [31:0]        od_ff;
   logic [7:0]         or_ff, og_ff, ob_ff;
   logic               olast_ff, oval_ff;

   logic signed [tvtc_pkg::MUL_A_W-1:0] mul_a;
   logic signed [tvtc_pkg::MUL_B_W-1:0] mul_b;
   logic signed [tvtc_pkg::PROD_W-1:0]  prod;
   logic        div_start, div_done;
   logic [NUM_W-1:0] div_num, div_quot;
   logic [31:0] div_den;

   logic [3:0]  pidx;
   logic signed [tvtc_pkg::ACC_W-1:0] acc_sum, acc_shr;
   logic signed [31:0] acc_sat;
   logic signed [31:0] sel_n, sel_d;
   logic signed [31:0] vz [3];
   logic signed [31:0] q_sat;
   logic signed [63:0] shade_raw;
   logic [1:0]  pnt;
   logic signed [63:0] sx_w, sy_w, dv;
   logic [63:0] dep_w;
   logic        out_free;

   assign pidx = 4'(cnt_ff - 5'd1);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == tvtc_pkg::ST_COL) begin
         mul_a = tvtc_pkg::MUL_A_W'({1'b0, shade_ff});
         mul_b = tvtc_pkg::MUL_B_W'({1'b0, colour_ff[8*pnt +: 8]});
      end else begin
         mul_a = tvtc_pkg::MUL_A_W'(vin_ff[cnt_ff[1:0]]);
         mul_b = tvtc_pkg::MUL_B_W'($signed(row_ff[cnt_ff[3:2]][16*cnt_ff[1:0] +: 16]));
      end
   end

   tvtc_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .prod(prod));

   tvtc_div #(.NUM_W(NUM_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(div_num), .denom(div_den), .done(div_done), .quot(div_quot)
   );

   assign acc_sum = acc_ff + tvtc_pkg::ACC_W'(prod);
   assign acc_shr = acc_sum >>> tvtc_pkg::MAT_FRAC;
   always_comb begin
      if (acc_shr > tvtc_pkg::ACC_W'(32'sh7FFF_FFFF)) acc_sat = 32'sh7FFF_FFFF;
      else if (acc_shr < -tvtc_pkg::ACC_W'(64'sh8000_0000)) acc_sat = 32'sh8000_0000;
      else acc_sat = acc_shr[31:0];
   end

   assign vz[0] = held_z_ff[0];
   assign vz[1] = held_z_ff[1];
   assign vz[2] = t_ff[2];

   always_comb begin
      sel_n = '0;
      unique case (comp_ff)
         2'd0: sel_n = (vtx_ff == 2'd2) ? t_ff[0] : held_x_ff[vtx_ff[0]];
         2'd1: sel_n = (vtx_ff == 2'd2) ? t_ff[1] : held_y_ff[vtx_ff[0]];
         default: sel_n = (vtx_ff == 2'd2) ? t_ff[2] : held_z_ff[vtx_ff[0]];
      endcase
      sel_d = (vtx_ff == 2'd2) ? t_ff[3] : held_w_ff[vtx_ff[0]];
   end

   assign div_start = (state_ff == tvtc_pkg::ST_DIVS);
   assign div_num = NUM_W'(sel_n[31] ? -(longint'(sel_n)) : longint'(sel_n)) << FRAC_BITS;
   assign div_den = sel_d[31] ? 32'(-(longint'(sel_d))) : sel_d;

   always_comb begin
      if (dzero_ff) q_sat = npos_ff ? 32'sh7FFF_FFFF : (neg_ff ? 32'sh8000_0000 : 32'sh0);
      else if (neg_ff) begin
         if (div_quot > NUM_W'(64'h8000_0000)) q_sat = 32'sh8000_0000;
         else q_sat = 32'(-(div_quot[31:0]));
      end else begin
         if (div_quot > NUM_W'(64'h7FFF_FFFF)) q_sat = 32'sh7FFF_FFFF;
         else q_sat = div_quot[31:0];
      end
   end

   assign shade_raw = (ONE_Q - 64'(dz_ff[0])) * 50;

   assign pnt = (cnt_ff[1:0] == 2'd3) ? 2'd0 : cnt_ff[1:0];
   assign sx_w = (ONE_Q + 64'(dx_ff[pnt])) * tvtc_pkg::HALF_X;
   assign sy_w = (ONE_Q - 64'(dy_ff[pnt])) * tvtc_pkg::HALF_Y;
   assign dv = 64'(dz_ff[pnt]) + ONE_Q;
   assign dep_w = 64'(dv) << DEPTH_SHIFT;
   assign out_free = !oval_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      corner_in = corner_ff;
      vtx_in = vtx_ff;
      comp_in = comp_ff;
      unique case (state_ff)
         tvtc_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) state_in = tvtc_pkg::ST_MUL;
         end
         tvtc_pkg::ST_MUL: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) state_in = tvtc_pkg::ST_DECIDE;
         end
         tvtc_pkg::ST_DECIDE: begin
            vtx_in = '0;
            comp_in = '0;
            if (corner_ff == 2'd0 || corner_ff == 2'd1) begin
               corner_in = corner_ff + 2'd1;
               state_in = tvtc_pkg::ST_IDLE;
            end else begin
               corner_in = '0;
               if (vz[0] <= 0 || vz[1] <= 0 || vz[2] <= 0) state_in = tvtc_pkg::ST_IDLE;
               else state_in = tvtc_pkg::ST_DIVS;
            end
         end
         tvtc_pkg::ST_DIVS: state_in = tvtc_pkg::ST_DIVW;
         tvtc_pkg::ST_DIVW: begin
            if (div_done) begin
               if (comp_ff == 2'd2) begin
                  comp_in = '0;
                  vtx_in = vtx_ff + 2'd1;
                  state_in = (vtx_ff == 2'd2) ? tvtc_pkg::ST_SHADE : tvtc_pkg::ST_DIVS;
               end else begin
                  comp_in = comp_ff + 2'd1;
                  state_in = tvtc_pkg::ST_DIVS;
               end
            end
         end
         tvtc_pkg::ST_SHADE: begin
            cnt_in = '0;
            if ((dx_ff[0] < -ONE_Q && dx_ff[1] < -ONE_Q && dx_ff[2] < -ONE_Q) ||
                (dx_ff[0] > ONE_Q && dx_ff[1] > ONE_Q && dx_ff[2] > ONE_Q))
               state_in = tvtc_pkg::ST_IDLE;
            else state_in = tvtc_pkg::ST_COL;
         end
         tvtc_pkg::ST_COL: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               cnt_in = '0;
               state_in = tvtc_pkg::ST_OUT;
            end
         end
         tvtc_pkg::ST_OUT: begin
            if (out_free) begin
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd3) state_in = tvtc_pkg::ST_IDLE;
            end
         end
         default: state_in = tvtc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tvtc_pkg::ST_IDLE;
         cnt_ff <= '0;
         corner_ff <= '0;
         vtx_ff <= '0;
         comp_ff <= '0;
         oval_ff <= 1'b0;
         colour_ff <= '0;
         for (int i = 0; i < 4; i++) row_ff[i] <= '0;
         for (int i = 0; i < 2; i++) begin
            held_x_ff[i] <= '0;
            held_y_ff[i] <= '0;
            held_z_ff[i] <= '0;
            held_w_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         corner_ff <= corner_in;
         vtx_ff <= vtx_in;
         comp_ff <= comp_in;
         if (csr_valid) begin
            unique case (csr_index)
               tvtc_pkg::CSR_ROW0: row_ff[0] <= csr_data;
               tvtc_pkg::CSR_ROW1: row_ff[1] <= csr_data;
               tvtc_pkg::CSR_ROW2: row_ff[2] <= csr_data;
               tvtc_pkg::CSR_ROW3: row_ff[3] <= csr_data;
               tvtc_pkg::CSR_COLOUR: colour_ff <= csr_data[23:0];
               default: ;
            endcase
         end
         if (state_ff == tvtc_pkg::ST_DECIDE &&
             (corner_ff == 2'd0 || corner_ff == 2'd1)) begin
            held_x_ff[corner_ff[0]] <= t_ff[0];
            held_y_ff[corner_ff[0]] <= t_ff[1];
            held_z_ff[corner_ff[0]] <= t_ff[2];
            held_w_ff[corner_ff[0]] <= t_ff[3];
         end
         if (state_ff == tvtc_pkg::ST_OUT && out_free) oval_ff <= 1'b1;
         else if (rsp_ready) oval_ff <= 1'b0;
      end
      if (state_ff == tvtc_pkg::ST_IDLE) begin
         vin_ff[0] <= req_vertex_x;
         vin_ff[1] <= req_vertex_y;
         vin_ff[2] <= req_vertex_z;
         vin_ff[3] <= req_vertex_w;
         acc_ff <= '0;
      end
      if (state_ff == tvtc_pkg::ST_MUL && cnt_ff != 5'd0) begin
         if (pidx[1:0] == 2'd3) begin
            t_ff[pidx[3:2]] <= acc_sat;
            acc_ff <= '0;
         end else acc_ff <= acc_sum;
      end
      if (state_ff == tvtc_pkg::ST_DIVS) begin
         neg_ff <= (sel_d == 0) ? sel_n[31] : (sel_n[31] ^ sel_d[31]);
         dzero_ff <= (sel_d == 0);
         npos_ff <= (sel_n > 0);
      end
      if (state_ff == tvtc_pkg::ST_DIVW && div_done) begin
         unique case (comp_ff)
            2'd0: dx_ff[vtx_ff] <= q_sat;
            2'd1: dy_ff[vtx_ff] <= q_sat;
            default: dz_ff[vtx_ff] <= q_sat;
         endcase
      end
      if (state_ff == tvtc_pkg::ST_SHADE) begin
         if (shade_raw < SHADE_MIN) shade_ff <= (FRAC_BITS+1)'(SHADE_MIN);
         else if (shade_raw > ONE_Q) shade_ff <= (FRAC_BITS+1)'(ONE_Q);
         else shade_ff <= shade_raw[FRAC_BITS:0];
      end
      if (state_ff == tvtc_pkg::ST_COL && cnt_ff != 5'd0)
         col_ff[pidx[1:0]] <= 8'(prod >>> FRAC_BITS);
      if (state_ff == tvtc_pkg::ST_OUT && out_free) begin
         ox_ff <= (sx_w > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                  (sx_w < -64'sh8000_0000) ? 32'sh8000_0000 : sx_w[31:0];
         oy_ff <= (sy_w > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                  (sy_w < -64'sh8000_0000) ? 32'sh8000_0000 : sy_w[31:0];
         od_ff <= (dv <= 0) ? 32'd0 : (dep_w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dep_w[31:0];
         or_ff <= col_ff[0];
         og_ff <= col_ff[1];
         ob_ff <= col_ff[2];
         olast_ff <= (cnt_ff[1:0] == 2'd3);
      end
   end

   assign req_ready = (state_ff == tvtc_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = oval_ff;
   assign rsp_screen_x = ox_ff;
   assign rsp_screen_y = oy_ff;
   assign rsp_point_depth = od_ff;
   assign rsp_red = or_ff;
   assign rsp_green = og_ff;
   assign rsp_blue = ob_ff;
   assign rsp_last_point = olast_ff;
endmodule

[tb/sv/tb_triangle_vertex_transform_cull_top.sv]
// self-checking testbench for the triangle vertex transform, cull and viewport block
module tb_triangle_vertex_transform_cull_top;
   localparam int ONE_Q = 1 << 16;
   localparam int SHADE_FLOOR = (ONE_Q * 5 + 50) / 100;
   localparam int SETTLE_CYCLES = 700;
   localparam int LONG_HOLD = 3000;
   localparam longint CYCLE_LIMIT = 1000000;
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 23;

   typedef struct {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic [31:0]        depth;
      logic [7:0]         r;
      logic [7:0]         g;
      logic [7:0]         b;
      logic               last;
   } point_type;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
      bit          typed;
      point_type   pt;
   } vertex_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_vertex_x = '0;
   logic signed [31:0] req_vertex_y = '0;
   logic signed [31:0] req_vertex_z = '0;
   logic signed [31:0] req_vertex_w = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_screen_x;
   logic signed [31:0] rsp_screen_y;
   logic [31:0] rsp_point_depth;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic rsp_last_point;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   triangle_vertex_transform_cull_top dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [63:0] matrix_rows[4];
   logic [23:0] colour_reg;
   int held_x[2], held_y[2], held_z[2], held_w[2];
   int corners;

   point_type expected_points[$];
   int mismatches = 0;
   longint cycle_count = 0;
   bit long_hold_req = 0;

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   function automatic int persp_div(int n, int d);
      longint num;
      num = longint'(n) * ONE_Q;
      if (d == 0) begin
         if (n > 0) return 32'h7FFFFFFF;
         if (n < 0) return 32'h80000000;
         return 0;
      end
      return sat32(num / longint'(d));
   endfunction

   function automatic logic [31:0] depth_of(int z);
      longint v;
      longint r;
      v = longint'(z) + ONE_Q;
      if (v <= 0) return 32'h0;
      r = v <<< 15;
      if (r > 64'h0FFFFFFFF) return 32'hFFFFFFFF;
      return r[31:0];
   endfunction

   task automatic predict_vertex(input int vin[4]);
      int t[4];
      int vx[3], vy[3], vz[3], vw[3], dx[3], dy[3], dz[3];
      longint sum, shade;
      logic [7:0] col[3];
      point_type p;
      int i;
      for (int r = 0; r < 4; r++) begin
         sum = 0;
         for (int c = 0; c < 4; c++)
            sum += longint'($signed(matrix_rows[r][16*c +: 16])) * longint'(vin[c]);
         t[r] = sat32(sum >>> tvtc_pkg::MAT_FRAC);
      end
      if (corners < 2) begin
         held_x[corners] = t[0]; held_y[corners] = t[1];
         held_z[corners] = t[2]; held_w[corners] = t[3];
         corners++;
         return;
      end
      corners = 0;
      for (int k = 0; k < 2; k++) begin
         vx[k] = held_x[k]; vy[k] = held_y[k]; vz[k] = held_z[k]; vw[k] = held_w[k];
      end
      vx[2] = t[0]; vy[2] = t[1]; vz[2] = t[2]; vw[2] = t[3];
      for (int k = 0; k < 3; k++)
         if (vz[k] <= 0) return;
      for (int k = 0; k < 3; k++) begin
         dx[k] = persp_div(vx[k], vw[k]);
         dy[k] = persp_div(vy[k], vw[k]);
         dz[k] = persp_div(vz[k], vw[k]);
      end
      if ((dx[0] < -ONE_Q && dx[1] < -ONE_Q && dx[2] < -ONE_Q) ||
          (dx[0] > ONE_Q && dx[1] > ONE_Q && dx[2] > ONE_Q))
         return;
      shade = (longint'(ONE_Q) - longint'(dz[0])) * 50;
      if (shade < SHADE_FLOOR) shade = SHADE_FLOOR;
      if (shade > ONE_Q) shade = ONE_Q;
      for (int c = 0; c < 3; c++)
         col[c] = 8'((longint'(colour_reg[8*c +: 8]) * shade) >>> 16);
      for (int k = 0; k < 4; k++) begin
         i = (k == 3) ? 0 : k;
         p.sx = sat32((longint'(ONE_Q) + dx[i]) * tvtc_pkg::HALF_X);
         p.sy = sat32((longint'(ONE_Q) - dy[i]) * tvtc_pkg::HALF_Y);
         p.depth = depth_of(dz[i]);
         p.r = col[0];
         p.g = col[1];
         p.b = col[2];
         p.last = (k == 3);
         expected_points.push_back(p);
      end
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 80);
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      if (idx == tvtc_pkg::CSR_COLOUR) colour_reg = data[23:0];
      else matrix_rows[idx] = data;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_vertex(input logic [31:0] x, y, z, w);
      int v[4];
      int g;
      @(negedge clock);
      req_valid = 1'b1;
      req_vertex_x = x; req_vertex_y = y; req_vertex_z = z; req_vertex_w = w;
      do @(posedge clock); while (!req_ready);
      v[0] = x; v[1] = y; v[2] = z; v[3] = w;
      predict_vertex(v);
      g = gap_len();
      if (g > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [63:0] pack_row(input logic [15:0] e0, e1, e2, e3);
      return {e3, e2, e1, e0};
   endfunction

   function automatic logic [15:0] near_entry(input bit diag);
      logic [15:0] e;
      e = 16'($urandom_range(0, 16'h0800)) - 16'h0400;
      if (diag) e = e + 16'h1000;
      return e;
   endfunction

   // receiver side
   initial begin
      int g;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_req = 0;
         end else begin
            g = gap_len();
            if (g > 0) begin
               rsp_ready = 1'b0;
               repeat (g) @(negedge clock);
            end
            rsp_ready = 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: x=%h y=%h d=%h", rsp_screen_x, rsp_screen_y,
                        rsp_point_depth);
         end else begin
            e = expected_points.pop_front();
            if (rsp_screen_x !== e.sx || rsp_screen_y !== e.sy ||
                rsp_point_depth !== e.depth || rsp_red !== e.r || rsp_green !== e.g ||
                rsp_blue !== e.b || rsp_last_point !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp x=%h y=%h d=%h rgb=%h%h%h l=%b ",
                            "got x=%h y=%h d=%h rgb=%h%h%h l=%b"},
                           e.sx, e.sy, e.depth, e.r, e.g, e.b, e.last,
                           rsp_screen_x, rsp_screen_y, rsp_point_depth,
                           rsp_red, rsp_green, rsp_blue, rsp_last_point);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   vertex_row_type directed[] = '{
      '{32'h0, 32'h0, 32'h8000, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h0, 32'h0, 32'h8000, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h0, 32'h0, 32'h8000, 32'h10000, 1,
        '{32'h01400000, 32'h00F00000, 32'hC0000000, 8'hFF, 8'hFF, 8'hFF, 0}},
      '{32'h0, 32'h0, 32'h10000, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h0, 32'h0, 32'h10000, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h0, 32'h0, 32'h10000, 32'h10000, 1,
        '{32'h01400000, 32'h00F00000, 32'hFFFFFFFF, 8'd12, 8'd12, 8'd12, 0}},
      '{32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h1, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h0, 32'h0, 32'h100, 32'h0, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h0, 32'h0, 32'h0, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h0, 32'h0, 32'h8000, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h0, 32'h0, 32'h8000, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'hFFFD0000, 32'h0, 32'h8000, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'hFFFD0000, 32'h10000, 32'h8000, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'hFFFD0000, 32'hFFFF0000, 32'h8000, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h00030000, 32'h0, 32'h8000, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h00030000, 32'h10000, 32'h8000, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h00030000, 32'hFFFF0000, 32'h8000, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h10000, 32'hFFFF0000, 32'h20000, 32'hFFFF0000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'h0, 32'h0, 32'h8000, 32'h10000, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{32'hFFFF8000, 32'h8000, 32'h4000, 32'h20000, 0, '{0, 0, 0, 0, 0, 0, 0}}
   };

   initial begin
      int before_n;
      logic [15:0] e[4][4];
      logic [31:0] x, y, z, w;
      for (int i = 0; i < 4; i++) matrix_rows[i] = '0;
      colour_reg = '0;
      corners = 0;
      for (int i = 0; i < 2; i++) begin
         held_x[i] = 0; held_y[i] = 0; held_z[i] = 0; held_w[i] = 0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero matrix straight after reset culls everything
      for (int i = 0; i < 3; i++) send_vertex(32'h10000, 32'h10000, 32'h10000, 32'h10000);
      wait_drained();

      csr_write(tvtc_pkg::CSR_ROW0, 64'h0000_0000_0000_1000);
      csr_write(tvtc_pkg::CSR_ROW1, 64'h0000_0000_1000_0000);
      csr_write(tvtc_pkg::CSR_ROW2, 64'h0000_1000_0000_0000);
      csr_write(tvtc_pkg::CSR_ROW3, 64'h1000_0000_0000_0000);
      csr_write(tvtc_pkg::CSR_COLOUR, 64'hFFFFFF);
      foreach (directed[i]) begin
         before_n = expected_points.size();
         send_vertex(directed[i].x, directed[i].y, directed[i].z, directed[i].w);
         if (directed[i].typed && expected_points.size() - before_n == 4)
            for (int k = 0; k < 4; k++) begin
               expected_points[before_n + k] = directed[i].pt;
               expected_points[before_n + k].last = (k == 3);
            end
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               case (p)
                  0: e[r][c] = 16'h7FFF;
                  1: e[r][c] = 16'h8000;
                  2: e[r][c] = 16'($urandom());
                  default: e[r][c] = near_entry(r == c);
               endcase
         csr_write(tvtc_pkg::CSR_ROW0, pack_row(e[0][0], e[0][1], e[0][2], e[0][3]));
         csr_write(tvtc_pkg::CSR_ROW1, pack_row(e[1][0], e[1][1], e[1][2], e[1][3]));
         csr_write(tvtc_pkg::CSR_ROW2, pack_row(e[2][0], e[2][1], e[2][2], e[2][3]));
         csr_write(tvtc_pkg::CSR_ROW3, pack_row(e[3][0], e[3][1], e[3][2], e[3][3]));
         case (p)
            0: csr_write(tvtc_pkg::CSR_COLOUR, 64'hFFFFFF);
            1: csr_write(tvtc_pkg::CSR_COLOUR, 64'h0);
            default: csr_write(tvtc_pkg::CSR_COLOUR, 64'($urandom_range(0, 24'hFFFFFF)));
         endcase
         if (p == 3) long_hold_req = 1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 15) begin
               x = $urandom(); y = $urandom(); z = $urandom(); w = $urandom();
            end else begin
               x = $urandom_range(0, 32'h60000) - 32'h30000;
               y = $urandom_range(0, 32'h60000) - 32'h30000;
               z = $urandom_range(1, 32'h18000);
               w = $urandom_range(32'h8000, 32'h40000);
            end
            send_vertex(x, y, z, w);
         end
      end

      wait_drained();
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

[files.f]
rtl/tvtc_pkg.sv
rtl/tvtc_mul.sv
rtl/tvtc_div.sv
rtl/triangle_vertex_transform_cull_top.sv
tb/sv/tb_triangle_vertex_transform_cull_top.sv
